/* hw/rtl/hvd_pkg.sv */
// Shared constants, widths and the CORDIC arctangent table for the haversine block.
`timescale 1ns / 1ps
`default_nettype none
package hvd_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int ANG_W = 34;
  localparam int DEG_W = 33;
  localparam int SQRT_STEPS = 31;
  localparam int SQRT_W = 62;

  localparam logic signed [ANG_W-1:0] DEG_90  = 34'sd754974720;
  localparam logic signed [ANG_W-1:0] DEG_180 = 34'sd1509949440;
  localparam logic signed [ANG_W-1:0] DEG_360 = 34'sd3019898880;
  localparam logic signed [62:0] RAD_PER_DEG_Q36 = 63'sd1199381129;
  localparam logic signed [ANG_W-1:0] GAIN_INV_Q30 = 34'sd652032874;
  localparam logic [30:0] Q_ONE = 31'h4000_0000;
  localparam logic [30:0] RADIUS_CM_RESET = 31'd637100000;
  localparam logic [6:0] CM_PER_M = 7'd100;

  function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0: v = 34'sh3243F6A8;
      1: v = 34'sh1DAC6705;
      2: v = 34'sh0FADBAFC;
      3: v = 34'sh07F56EA6;
      4: v = 34'sh03FEAB76;
      5: v = 34'sh01FFD55B;
      6: v = 34'sh00FFFAAA;
      7: v = 34'sh007FFF55;
      8: v = 34'sh003FFFEA;
      9: v = 34'sh001FFFFD;
      10: v = 34'sh000FFFFF;
      11: v = 34'sh0007FFFF;
      12: v = 34'sh0003FFFF;
      13: v = 34'sh0001FFFF;
      14: v = 34'sh0000FFFF;
      15: v = 34'sh00007FFF;
      16: v = 34'sh00003FFF;
      17: v = 34'sh00001FFF;
      18: v = 34'sh00000FFF;
      19: v = 34'sh000007FF;
      20: v = 34'sh000003FF;
      21: v = 34'sh000001FF;
      22: v = 34'sh000000FF;
      23: v = 34'sh0000007F;
      24: v = 34'sh0000003F;
      25: v = 34'sh0000001F;
      26: v = 34'sh0000000F;
      27: v = 34'sh00000008;
      28: v = 34'sh00000004;
      29: v = 34'sh00000002;
      30: v = 34'sh00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/hvd_sincos.sv */
// Pipelined sine/cosine: range reduction, degree to radian scaling, rotation CORDIC.
`timescale 1ns / 1ps
`default_nettype none
module hvd_sincos #(
  parameter int STAGES = hvd_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic signed [hvd_pkg::DEG_W-1:0]  in_deg,
  output logic                                   out_valid,
  output logic signed [hvd_pkg::ANG_W-1:0]       out_sin,
  output logic signed [hvd_pkg::ANG_W-1:0]       out_cos
);

  localparam int W = hvd_pkg::ANG_W;

  logic signed [W-1:0] d, r;
  logic signed [30:0]  fold_nxt, fold_r;
  logic                neg_nxt;
  logic                s1_v_r, s2_v_r, s1_neg_r, s2_neg_r;
  logic signed [62:0]  prod_r, prod_rnd;

  logic signed [W-1:0] x_r [0:STAGES];
  logic signed [W-1:0] y_r [0:STAGES];
  logic signed [W-1:0] z_r [0:STAGES];
  logic                n_r [0:STAGES];
  logic                v_r [0:STAGES];

  // reduce into (-180, 180], then fold into [-90, 90]
  always_comb begin
    d = W'(in_deg);
    if (d > hvd_pkg::DEG_180) begin
      r = d - hvd_pkg::DEG_360;
    end else if (d <= -hvd_pkg::DEG_180) begin
      r = d + hvd_pkg::DEG_360;
    end else begin
      r = d;
    end
    neg_nxt = 1'b0;
    if (r > hvd_pkg::DEG_90) begin
      fold_nxt = 31'(hvd_pkg::DEG_180 - r);
      neg_nxt  = 1'b1;
    end else if (r < -hvd_pkg::DEG_90) begin
      fold_nxt = 31'(-hvd_pkg::DEG_180 - r);
      neg_nxt  = 1'b1;
    end else begin
      fold_nxt = 31'(r);
    end
  end

  assign prod_rnd = (prod_r + 63'sd268435456) >>> 29;

  always_ff @(posedge clk) begin
    if (en) begin
      fold_r   <= fold_nxt;
      s1_neg_r <= neg_nxt;
      prod_r   <= 63'(fold_r) * hvd_pkg::RAD_PER_DEG_Q36;
      s2_neg_r <= s1_neg_r;
      x_r[0]   <= hvd_pkg::GAIN_INV_Q30;
      y_r[0]   <= '0;
      z_r[0]   <= W'(prod_rnd);
      n_r[0]   <= s2_neg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      v_r[0] <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      v_r[0] <= s2_v_r;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i+1] <= n_r[i];
        if (!z_r[i][W-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - hvd_pkg::atan_q30(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + hvd_pkg::atan_q30(i);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end
  end

  assign out_valid = v_r[STAGES];
  assign out_sin   = y_r[STAGES];
  assign out_cos   = n_r[STAGES] ? -x_r[STAGES] : x_r[STAGES];

endmodule
`default_nettype wire

/* hw/rtl/hvd_isqrt.sv */
// Pipelined integer floor square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module hvd_isqrt (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic [hvd_pkg::SQRT_W-1:0]        in_val,
  output logic                                   out_valid,
  output logic [30:0]                            out_root
);

  localparam int N = hvd_pkg::SQRT_STEPS;
  localparam int W = hvd_pkg::SQRT_W;

  logic [W-1:0] rem_r [0:N];
  logic [W-1:0] res_r [0:N];
  logic         v_r   [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= in_val;
      res_r[0] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - k));
    logic [W-1:0] trial;
    assign trial = res_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_r[k] >= trial) begin
          rem_r[k+1] <= rem_r[k] - trial;
          res_r[k+1] <= (res_r[k] >> 1) + BIT;
        end else begin
          rem_r[k+1] <= rem_r[k];
          res_r[k+1] <= res_r[k] >> 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  assign out_valid = v_r[N];
  assign out_root  = res_r[N][30:0];

endmodule
`default_nettype wire

/* hw/rtl/hvd_vector.sv */
// Pipelined vectoring CORDIC: first-quadrant atan2 of two square roots.
`timescale 1ns / 1ps
`default_nettype none
module hvd_vector #(
  parameter int STAGES = hvd_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [30:0] in_y,
  input  wire logic [30:0] in_x,
  output logic             out_valid,
  output logic [30:0]      out_angle
);

  localparam int W = hvd_pkg::ANG_W;

  logic signed [W-1:0] x_r [0:STAGES];
  logic signed [W-1:0] y_r [0:STAGES];
  logic signed [W-1:0] z_r [0:STAGES];
  logic                v_r [0:STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= W'(signed'({1'b0, in_x}));
      y_r[0] <= W'(signed'({1'b0, in_y}));
      z_r[0] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[i][W-1]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + hvd_pkg::atan_q30(i);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - hvd_pkg::atan_q30(i);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end
  end

  // clamp a slightly negative angle to zero
  assign out_valid = v_r[STAGES];
  assign out_angle = z_r[STAGES][W-1] ? '0 : z_r[STAGES][30:0];

endmodule
`default_nettype wire

/* hw/rtl/haversine_distance_top.sv */
// Top level: haversine distance pipeline with radius register and output skid stage.
// Throughput: one point pair per cycle while the skid register is empty (in_tready high);
// every pipeline stage ahead of the output and skid registers is a register on a shared advance enable.
// The unrolled CORDIC chains and the 31-step square root pipelines set the latency.
// A skid register behind the output lets in_tready stay registered; a held result stalls
// the pipeline only once the skid register is full.
// Reset (rst_n low, synchronous) clears all valid bits and sets the radius to 6371000 m.
`timescale 1ns / 1ps
`default_nettype none
module haversine_distance_top #(
  parameter int CORDIC_STAGES = hvd_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic [23:0]  cfg_wr_data,   // radius_metres
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // first_latitude[29:0], first_longitude[60:30], second_latitude[90:61],
  // second_longitude[121:91], zero fill[127:122]
  input  wire logic [127:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [31:0]       out_tdata,     // distance_cm[31:0]
  output logic              out_tuser      // saturated[0]
);

  localparam int DW = hvd_pkg::DEG_W;
  localparam int AW = hvd_pkg::ANG_W;

  logic        en;
  logic [30:0] radius_cm_r;

  logic                 s0_v_r;
  logic signed [DW-1:0] dlat_r, dlon_r, lat1_r, lat2_r;

  logic sc_v;
  logic signed [AW-1:0] s_lat, c_lat, s_lon, c_lon, s1, c1, s2, c2;

  logic               c1_v_r, c2_v_r, c3_v_r, c4_v_r;
  logic signed [63:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [AW-1:0] r1_r, r2_r, r3_r, r1b_r;
  logic signed [63:0] r1x, r4x;
  logic signed [AW-1:0] a_sum;
  logic [30:0]        a_r;

  logic        sq_v;
  logic [30:0] root_a, root_b;
  logic        vec_v;
  logic [30:0] angle;

  logic        f1_v_r;
  logic [61:0] f1_prod_r;
  logic [63:0] dist_sum;
  logic [33:0] dist_cm;

  logic        out_v_r, skid_v_r;
  logic [31:0] out_d_r, skid_d_r;
  logic        out_s_r, skid_s_r;
  logic        arrive;
  logic [31:0] new_d;
  logic        new_s;

  assign en        = !skid_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_cm_r <= hvd_pkg::RADIUS_CM_RESET;
    end else if (cfg_wr_en) begin
      radius_cm_r <= 31'(cfg_wr_data) * 31'(hvd_pkg::CM_PER_M);
    end
  end

  // a difference in q22 degrees is half that difference in q23
  always_ff @(posedge clk) begin
    if (en) begin
      dlat_r <= DW'(signed'(in_tdata[90:61])) - DW'(signed'(in_tdata[29:0]));
      dlon_r <= DW'(signed'(in_tdata[121:91])) - DW'(signed'(in_tdata[60:30]));
      lat1_r <= DW'(signed'({in_tdata[29:0], 1'b0}));
      lat2_r <= DW'(signed'({in_tdata[90:61], 1'b0}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_tvalid;
    end
  end

  hvd_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlat (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s0_v_r), .in_deg(dlat_r),
    .out_valid(sc_v), .out_sin(s_lat), .out_cos(c_lat)
  );
  hvd_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlon (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s0_v_r), .in_deg(dlon_r),
    .out_valid(), .out_sin(s_lon), .out_cos(c_lon)
  );
  hvd_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s0_v_r), .in_deg(lat1_r),
    .out_valid(), .out_sin(s1), .out_cos(c1)
  );
  hvd_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s0_v_r), .in_deg(lat2_r),
    .out_valid(), .out_sin(s2), .out_cos(c2)
  );

  // a = sin^2(dlat/2) + cos(lat1) cos(lat2) sin^2(dlon/2), Q30
  assign r4x   = (p4_r + 64'sd536870912) >>> 30;
  assign r1x   = 64'(r1b_r);
  assign a_sum = AW'(r1x + r4x);

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= 64'(signed'(s_lat[31:0])) * 64'(signed'(s_lat[31:0]));
      p2_r  <= 64'(signed'(c1[31:0])) * 64'(signed'(c2[31:0]));
      p3_r  <= 64'(signed'(s_lon[31:0])) * 64'(signed'(s_lon[31:0]));
      r1_r  <= AW'((p1_r + 64'sd536870912) >>> 30);
      r2_r  <= AW'((p2_r + 64'sd536870912) >>> 30);
      r3_r  <= AW'((p3_r + 64'sd536870912) >>> 30);
      p4_r  <= 64'(r2_r) * 64'(r3_r);
      r1b_r <= r1_r;
      if (a_sum[AW-1]) begin
        a_r <= '0;
      end else if (a_sum > AW'(hvd_pkg::Q_ONE)) begin
        a_r <= hvd_pkg::Q_ONE;
      end else begin
        a_r <= a_sum[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
      c2_v_r <= 1'b0;
      c3_v_r <= 1'b0;
      c4_v_r <= 1'b0;
    end else if (en) begin
      c1_v_r <= sc_v;
      c2_v_r <= c1_v_r;
      c3_v_r <= c2_v_r;
      c4_v_r <= c3_v_r;
    end
  end

  hvd_isqrt u_sqrt_a (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(c4_v_r),
    .in_val({1'b0, a_r, 30'd0}),
    .out_valid(sq_v), .out_root(root_a)
  );
  hvd_isqrt u_sqrt_b (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(c4_v_r),
    .in_val({1'b0, hvd_pkg::Q_ONE - a_r, 30'd0}),
    .out_valid(), .out_root(root_b)
  );

  hvd_vector #(.STAGES(CORDIC_STAGES)) u_vec (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sq_v),
    .in_y(root_a), .in_x(root_b),
    .out_valid(vec_v), .out_angle(angle)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      f1_prod_r <= 62'(angle) * 62'(radius_cm_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= vec_v;
    end
  end

  // distance = (2 c r + half) >> 30, clamp when it overflows 32 bits
  assign dist_sum = {1'b0, f1_prod_r, 1'b0} + 64'd536870912;
  assign dist_cm  = dist_sum[63:30];
  assign new_s    = dist_cm[33:32] != 2'b00;
  assign new_d    = new_s ? '1 : dist_cm[31:0];
  assign arrive   = en && f1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (arrive) begin
      if (out_v_r && !out_tready) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_d_r <= skid_d_r;
        out_s_r <= skid_s_r;
      end
    end else if (arrive) begin
      if (out_v_r && !out_tready) begin
        skid_d_r <= new_d;
        skid_s_r <= new_s;
      end else begin
        out_d_r <= new_d;
        out_s_r <= new_s;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_s_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds a transaction while output is empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready && f1_v_r))
    else $error("skid register filled without a stalled output");

  a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 32'hFFFF_FFFF))
    else $error("saturated result not clamped to maximum");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_v_r && !skid_v_r))
    else $error("reset left a transaction pending");

endmodule
`default_nettype wire
